@@ rtl/lqr_quad_motor_mixer_macros.svh @@
// Assertion macros used by the mixer top level.
`ifndef LQR_QUAD_MOTOR_MIXER_MACROS_SVH
`define LQR_QUAD_MOTOR_MIXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LQRM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lqrm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LQRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lqrm assertion failed");

`endif

@@ rtl/lqrm_pkg.sv @@
// Types, constants and register codes of the quadrotor motor mixer.
package lqrm_pkg;

   localparam int unsigned MOTOR_COUNT = 4;
   localparam int unsigned DEG_COUNT   = 9;
   localparam int unsigned DEG_W       = 32;
   localparam int unsigned GAIN_W      = 32;
   localparam int unsigned BASE_W      = 16;
   localparam int unsigned POWER_W     = 16;
   localparam int unsigned RAD_W       = 27;
   localparam int unsigned YSUM_W      = RAD_W + 1;
   localparam int unsigned MIX_W       = 29;
   localparam int unsigned SUM_W       = 64;
   localparam int unsigned T_W         = 33;

   // Slots of the degree inputs, in beat order.
   localparam int unsigned SLOT_ANGLE_ROLL  = 0;
   localparam int unsigned SLOT_ANGLE_PITCH = 1;
   localparam int unsigned SLOT_ANGLE_YAW   = 2;
   localparam int unsigned SLOT_RATE_ROLL   = 3;
   localparam int unsigned SLOT_RATE_PITCH  = 4;
   localparam int unsigned SLOT_RATE_YAW    = 5;
   localparam int unsigned SLOT_REF_ROLL    = 6;
   localparam int unsigned SLOT_REF_PITCH   = 7;
   localparam int unsigned SLOT_REF_YAW     = 8;

   // pi/180 in Q32, and the thrust-to-PWM polynomial coefficients.
   localparam logic signed [27:0]      D2R_Q32    = 28'sd74961321;
   localparam logic [24:0]             POLY_A_Q8  = 25'd19487921;
   localparam logic signed [26:0]      POLY_B_Q8  = 27'sd38157978;
   localparam logic signed [SUM_W-1:0] POLY_C_Q36 = 64'sd78044709729075;
   localparam logic signed [SUM_W-1:0] T_LIMIT_Q44 = 64'sh0000_8000_0000_0000;

   // Bit m set where the sign of that matrix column is negative for motor m.
   localparam logic [MOTOR_COUNT-1:0] NEG_ROLL  = 4'b0011;
   localparam logic [MOTOR_COUNT-1:0] NEG_PITCH = 4'b0110;
   localparam logic [MOTOR_COUNT-1:0] NEG_PRATE = 4'b1001;
   localparam logic [MOTOR_COUNT-1:0] NEG_YAW   = 4'b0101;

   // Register file.
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_ANGLE_GAIN        = 2'd0;
   localparam logic [1:0] REG_ANGLE_RATE_GAIN   = 2'd1;
   localparam logic [1:0] REG_HEADING_GAIN      = 2'd2;
   localparam logic [1:0] REG_HEADING_RATE_GAIN = 2'd3;

   localparam logic signed [GAIN_W-1:0] RESET_ANGLE_GAIN        = 32'sd18790482;
   localparam logic signed [GAIN_W-1:0] RESET_ANGLE_RATE_GAIN   = 32'sd8053064;
   localparam logic signed [GAIN_W-1:0] RESET_HEADING_GAIN      = 32'sd134218;
   localparam logic signed [GAIN_W-1:0] RESET_HEADING_RATE_GAIN = 32'sd5368709;

   typedef logic signed [GAIN_W-1:0] gain_type;

   typedef struct packed {
      gain_type angle;
      gain_type angle_rate;
      gain_type heading;
      gain_type heading_rate;
   } gains_type;

   typedef struct packed {
      logic [MOTOR_COUNT-1:0][MIX_W-1:0] ang_mix;
      logic [MOTOR_COUNT-1:0][MIX_W-1:0] rate_mix;
      logic [RAD_W-1:0]                  yaw_angle;
      logic [YSUM_W-1:0]                 yaw_sum;
      logic [BASE_W-1:0]                 base;
   } mix_type;

   typedef struct packed {
      logic [MOTOR_COUNT-1:0][T_W-1:0] thrust;
      logic [BASE_W-1:0]               base;
   } thrust_type;

   typedef logic [MOTOR_COUNT-1:0][POWER_W-1:0] power_type;

endpackage

@@ rtl/lqrm_rad_stage.sv @@
// Degree-to-radian conversion and per-motor mixing of the state errors.
module lqrm_rad_stage
   import lqrm_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              ce,
   input  logic                              in_valid,
   input  logic [DEG_COUNT-1:0][DEG_W-1:0]   in_deg,
   input  logic [BASE_W-1:0]                 in_base,
   output logic                              out_valid,
   output mix_type                           out_mix
);

   localparam int unsigned DPROD_W = DEG_W + 28;
   localparam logic signed [DPROD_W-1:0] ROUND_HALF = DPROD_W'(64'sd2147483648);

   logic                       s1_valid_ff;
   logic signed [DPROD_W-1:0]  s1_prod_ff [DEG_COUNT];
   logic signed [DPROD_W-1:0]  s1_prod_in [DEG_COUNT];
   logic [BASE_W-1:0]          s1_base_ff;

   logic                       s2_valid_ff;
   mix_type                    s2_mix_ff;
   mix_type                    s2_mix_in;

   logic signed [DPROD_W-1:0]  rounded [DEG_COUNT];
   logic signed [RAD_W-1:0]    rad [DEG_COUNT];
   logic signed [MIX_W-1:0]    err_roll;
   logic signed [MIX_W-1:0]    err_pitch;
   logic signed [MIX_W-1:0]    w_roll;
   logic signed [MIX_W-1:0]    w_pitch;

   always_comb begin
      for (int i = 0; i < DEG_COUNT; i++) begin
         s1_prod_in[i] = $signed(in_deg[i]) * D2R_Q32;
      end
   end

   // Round to nearest by adding one half before the floor shift.
   always_comb begin
      for (int i = 0; i < DEG_COUNT; i++) begin
         rounded[i] = s1_prod_ff[i] + ROUND_HALF;
         rad[i]     = rounded[i][32 +: RAD_W];
      end
      err_roll  = MIX_W'(rad[SLOT_REF_ROLL])  - MIX_W'(rad[SLOT_ANGLE_ROLL]);
      err_pitch = MIX_W'(rad[SLOT_REF_PITCH]) - MIX_W'(rad[SLOT_ANGLE_PITCH]);
      w_roll    = MIX_W'(rad[SLOT_RATE_ROLL]);
      w_pitch   = MIX_W'(rad[SLOT_RATE_PITCH]);
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         s2_mix_in.ang_mix[m]  = (NEG_ROLL[m]  ? -err_roll  : err_roll)
                               + (NEG_PITCH[m] ? -err_pitch : err_pitch);
         s2_mix_in.rate_mix[m] = (NEG_ROLL[m]  ? w_roll  : -w_roll)
                               + (NEG_PRATE[m] ? w_pitch : -w_pitch);
      end
      s2_mix_in.yaw_angle = rad[SLOT_ANGLE_YAW];
      // The yaw reference enters negated, so reference and rate share one sign.
      s2_mix_in.yaw_sum   = YSUM_W'(rad[SLOT_REF_YAW]) + YSUM_W'(rad[SLOT_RATE_YAW]);
      s2_mix_in.base      = s1_base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (ce) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < DEG_COUNT; i++) begin
            s1_prod_ff[i] <= s1_prod_in[i];
         end
         s1_base_ff <= in_base;
         s2_mix_ff  <= s2_mix_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_mix   = s2_mix_ff;

endmodule

@@ rtl/lqrm_gain_stage.sv @@
// Gain products, per-motor thrust sums and the thrust clamp.
module lqrm_gain_stage
   import lqrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       ce,
   input  gains_type  gains,
   input  logic       in_valid,
   input  mix_type    in_mix,
   output logic       out_valid,
   output thrust_type out_thrust
);

   localparam int unsigned MPROD_W = GAIN_W + MIX_W;
   localparam int unsigned HPROD_W = GAIN_W + RAD_W;
   localparam int unsigned RPROD_W = GAIN_W + YSUM_W;

   logic                       s3_valid_ff;
   logic signed [MPROD_W-1:0]  s3_ang_ff  [MOTOR_COUNT];
   logic signed [MPROD_W-1:0]  s3_rate_ff [MOTOR_COUNT];
   logic signed [HPROD_W-1:0]  s3_head_ff;
   logic signed [RPROD_W-1:0]  s3_hrate_ff;
   logic [BASE_W-1:0]          s3_base_ff;

   logic                       s4_valid_ff;
   logic signed [SUM_W-1:0]    s4_pair_ff [MOTOR_COUNT];
   logic signed [SUM_W-1:0]    s4_yaw_ff;
   logic [BASE_W-1:0]          s4_base_ff;

   logic                       s5_valid_ff;
   thrust_type                 s5_thrust_ff;
   thrust_type                 s5_thrust_in;

   logic signed [SUM_W-1:0]    total [MOTOR_COUNT];
   logic signed [SUM_W-1:0]    clamped [MOTOR_COUNT];

   always_comb begin
      s5_thrust_in.base = s4_base_ff;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         // The yaw terms belong to K*x, which the thrust subtracts, so a
         // negative yaw column adds them.
         total[m] = s4_pair_ff[m] + (NEG_YAW[m] ? s4_yaw_ff : -s4_yaw_ff);
         if (total[m] > T_LIMIT_Q44) begin
            clamped[m] = T_LIMIT_Q44;
         end else if (total[m] < -T_LIMIT_Q44) begin
            clamped[m] = -T_LIMIT_Q44;
         end else begin
            clamped[m] = total[m];
         end
         // Floor from Q44 to Q28.
         s5_thrust_in.thrust[m] = clamped[m][16 +: T_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (ce) begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            s3_ang_ff[m]  <= $signed(gains.angle) * $signed(in_mix.ang_mix[m]);
            s3_rate_ff[m] <= $signed(gains.angle_rate) * $signed(in_mix.rate_mix[m]);
            s4_pair_ff[m] <= SUM_W'(s3_ang_ff[m]) + SUM_W'(s3_rate_ff[m]);
         end
         s3_head_ff   <= $signed(gains.heading) * $signed(in_mix.yaw_angle);
         s3_hrate_ff  <= $signed(gains.heading_rate) * $signed(in_mix.yaw_sum);
         s3_base_ff   <= in_mix.base;
         s4_yaw_ff    <= SUM_W'(s3_head_ff) + SUM_W'(s3_hrate_ff);
         s4_base_ff   <= s3_base_ff;
         s5_thrust_ff <= s5_thrust_in;
      end
   end

   assign out_valid  = s5_valid_ff;
   assign out_thrust = s5_thrust_ff;

endmodule

@@ rtl/lqrm_pwm_stage.sv @@
// Quadratic thrust-to-PWM map, base thrust and output saturation.
module lqrm_pwm_stage
   import lqrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       ce,
   input  logic       in_valid,
   input  thrust_type in_thrust,
   output logic       out_valid,
   output power_type  out_power
);

   localparam int unsigned SQP_W = 2 * T_W;
   localparam int unsigned SQ_W  = 63;
   localparam int unsigned T2_W  = SQ_W - 28;
   localparam int unsigned BT_W  = T_W + 27;
   localparam int unsigned AT2_W = T2_W + 25;
   localparam int unsigned Q_W   = SUM_W - 36;

   logic                       s6_valid_ff;
   logic [SQ_W-1:0]            s6_sq_ff [MOTOR_COUNT];
   logic signed [BT_W-1:0]     s6_bt_ff [MOTOR_COUNT];
   logic [BASE_W-1:0]          s6_base_ff;
   logic signed [SQP_W-1:0]    sq_full [MOTOR_COUNT];

   logic                       s7_valid_ff;
   logic [AT2_W-1:0]           s7_at2_ff [MOTOR_COUNT];
   logic signed [SUM_W-1:0]    s7_off_ff [MOTOR_COUNT];

   logic signed [SUM_W-1:0]    poly [MOTOR_COUNT];
   logic [Q_W-1:0]             whole [MOTOR_COUNT];

   always_comb begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         sq_full[m] = $signed(in_thrust.thrust[m]) * $signed(in_thrust.thrust[m]);
      end
   end

   // Truncate toward zero and saturate to the 16-bit drive range.
   always_comb begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         poly[m]  = s7_off_ff[m] - $signed(SUM_W'(s7_at2_ff[m]));
         whole[m] = poly[m][SUM_W-1:36];
         if (poly[m][SUM_W-1]) begin
            out_power[m] = '0;
         end else if (|whole[m][Q_W-1:POWER_W]) begin
            out_power[m] = '1;
         end else begin
            out_power[m] = whole[m][POWER_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (ce) begin
         s6_valid_ff <= in_valid;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            s6_sq_ff[m]  <= sq_full[m][SQ_W-1:0];
            s6_bt_ff[m]  <= $signed(in_thrust.thrust[m]) * POLY_B_Q8;
            s7_at2_ff[m] <= s6_sq_ff[m][SQ_W-1:28] * POLY_A_Q8;
            s7_off_ff[m] <= SUM_W'(s6_bt_ff[m]) + POLY_C_Q36
                          + $signed(SUM_W'({s6_base_ff, 36'd0}));
         end
         s6_base_ff <= in_thrust.base;
      end
   end

   assign out_valid = s7_valid_ff;

endmodule

@@ rtl/lqrm_out_skid.sv @@
// Output register with a skid entry that holds one beat while the receiver stalls.
module lqrm_out_skid
   import lqrm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  power_type in_data,
   output logic      in_ready,
   output logic      out_valid,
   output power_type out_data,
   input  logic      out_ready
);

   logic      out_valid_ff;
   logic      out_valid_in;
   power_type out_data_ff;
   power_type out_data_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   power_type skid_data_ff;
   power_type skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !out_ready) begin
         if (in_valid) begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else begin
         out_valid_in = in_valid;
         out_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ rtl/lqr_quad_motor_mixer.sv @@
// Top level of the quadrotor LQR state-feedback motor mixer.
//
// One beat on the req_ channel carries a sensor sample: nine Q16.16 degree
// values (angles, gyro rates, references) and a base thrust in tdata, and the
// calibrated flag in tuser. A beat with the flag low is accepted and dropped.
// Each calibrated beat yields one rsp_ beat with the four saturated motor drive
// values, motor 1 in the lowest 16 bits.
// The datapath is an eight-register pipeline: two stages of degree-to-radian
// conversion and error mixing, three of gain products, sums and clamp, two of
// the PWM polynomial, and the output register. A sample passes through these
// registers in that order before rsp_tvalid rises, and one sample can be
// accepted every cycle while the skid entry is free.
// When the receiver stalls, the output register holds its beat and the skid
// entry catches the one beat still moving; req_tready then drops for as long
// as the skid entry is occupied, and the whole pipeline freezes in place.
// Reset clears every valid bit and loads the four gain registers with their
// default values. The gains are written over the csr_ port, which completes a
// write in its access cycle and should be used only while the block is idle.
`include "lqr_quad_motor_mixer_macros.svh"

module lqr_quad_motor_mixer
   import lqrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // angle_roll, angle_pitch, angle_yaw, rate_roll, rate_pitch, rate_yaw,
   // ref_roll, ref_pitch, ref_yaw (32 bits each), base_thrust (16 bits)
   input  logic [303:0]          req_tdata,
   // calibrated
   input  logic [0:0]            req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // motor1_power, motor2_power, motor3_power, motor4_power (16 bits each)
   output logic [63:0]           rsp_tdata,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   gains_type  gains_ff;
   gains_type  gains_in;
   logic       csr_write;
   logic [1:0] csr_reg;

   logic       pipe_ready;
   logic       entry_valid;
   logic       mix_valid;
   mix_type    mix_data;
   logic       thrust_valid;
   thrust_type thrust_data;
   logic       pwm_valid;
   power_type  pwm_power;
   power_type  rsp_power;

   // Register file: always ready, write lands in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_paddr[3:2];

   always_comb begin
      gains_in = gains_ff;
      if (csr_write) begin
         case (csr_reg)
            REG_ANGLE_GAIN:        gains_in.angle        = csr_pwdata;
            REG_ANGLE_RATE_GAIN:   gains_in.angle_rate   = csr_pwdata;
            REG_HEADING_GAIN:      gains_in.heading      = csr_pwdata;
            REG_HEADING_RATE_GAIN: gains_in.heading_rate = csr_pwdata;
            default:               gains_in = gains_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_ANGLE_GAIN:        csr_prdata = gains_ff.angle;
         REG_ANGLE_RATE_GAIN:   csr_prdata = gains_ff.angle_rate;
         REG_HEADING_GAIN:      csr_prdata = gains_ff.heading;
         REG_HEADING_RATE_GAIN: csr_prdata = gains_ff.heading_rate;
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.angle        <= RESET_ANGLE_GAIN;
         gains_ff.angle_rate   <= RESET_ANGLE_RATE_GAIN;
         gains_ff.heading      <= RESET_HEADING_GAIN;
         gains_ff.heading_rate <= RESET_HEADING_RATE_GAIN;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // The pipeline advances whenever the skid entry is free.
   assign req_tready  = pipe_ready;
   assign entry_valid = req_tvalid && pipe_ready && req_tuser[0];

   lqrm_rad_stage u_rad (
      .clock     (clock),
      .reset     (reset),
      .ce        (pipe_ready),
      .in_valid  (entry_valid),
      .in_deg    (req_tdata[DEG_COUNT*DEG_W-1:0]),
      .in_base   (req_tdata[DEG_COUNT*DEG_W +: BASE_W]),
      .out_valid (mix_valid),
      .out_mix   (mix_data)
   );

   lqrm_gain_stage u_gain (
      .clock      (clock),
      .reset      (reset),
      .ce         (pipe_ready),
      .gains      (gains_ff),
      .in_valid   (mix_valid),
      .in_mix     (mix_data),
      .out_valid  (thrust_valid),
      .out_thrust (thrust_data)
   );

   lqrm_pwm_stage u_pwm (
      .clock     (clock),
      .reset     (reset),
      .ce        (pipe_ready),
      .in_valid  (thrust_valid),
      .in_thrust (thrust_data),
      .out_valid (pwm_valid),
      .out_power (pwm_power)
   );

   lqrm_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pwm_valid),
      .in_data   (pwm_power),
      .in_ready  (pipe_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_power),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = rsp_power;

   // The skid entry is only ever occupied behind a waiting output beat.
   `LQRM_ASSERT_SAME(a_skid_behind_output, clock, reset, !pipe_ready, rsp_tvalid)

   // Draining the skid entry leaves a valid beat in the output register.
   `LQRM_ASSERT_NEXT(a_skid_drains_to_output, clock, reset,
                     !pipe_ready && rsp_tready, rsp_tvalid && pipe_ready)

   // A stalled output with a finished beat arriving must fill the skid entry.
   `LQRM_ASSERT_NEXT(a_skid_catches_beat, clock, reset,
                     pipe_ready && pwm_valid && rsp_tvalid && !rsp_tready, !pipe_ready)

   // While frozen, the last pipeline stage keeps its beat.
   `LQRM_ASSERT_NEXT(a_pipe_frozen, clock, reset,
                     !pipe_ready && !rsp_tready, $stable(pwm_valid) && $stable(pwm_power))

endmodule
